FILE: design/fpltq_pkg.sv
// ----------------------------------------------------------------------------
// fpltq_pkg: shared types and constants of the four-level trap queue
// Request and result payloads, request and status codes, controller states,
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package fpltq_pkg;

	// queue geometry
	localparam int QUEUE_DEPTH = 16;   // entries per level, 1..16
	localparam int LEVELS      = 4;
	localparam int LVL_W       = 2;
	localparam int SLOTS       = 16;   // store slots reserved per level
	localparam int SLOT_W      = 4;
	localparam int ADDR_W      = LVL_W + SLOT_W;
	localparam int CNT_W       = 5;
	localparam int TOT_W       = 7;

	localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(QUEUE_DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_M1  = CNT_W'(QUEUE_DEPTH - 1);
	localparam logic [LVL_W-1:0] MAX_LVL   = LVL_W'(LEVELS - 1);
	localparam logic [7:0]       MAX_LVL_B = 8'(LEVELS - 1);

	// request kinds
	localparam logic [1:0] REQ_QUEUE   = 2'd0;
	localparam logic [1:0] REQ_ENABLE  = 2'd1;
	localparam logic [1:0] REQ_DELIVER = 2'd2;

	// result status codes
	localparam logic [2:0] ST_NORMAL   = 3'd0;
	localparam logic [2:0] ST_BADPARAM = 3'd1;
	localparam logic [2:0] ST_LIMIT    = 3'd2;
	localparam logic [2:0] ST_WASCLR   = 3'd3;
	localparam logic [2:0] ST_WASSET   = 3'd4;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] handler_token;
		logic [31:0] trap_param;
		logic [7:0]  level_req;
		logic        enable_bit;
		logic [1:0]  cur_level;
	} req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic             has_entry;
		logic [31:0]      out_handler;
		logic [31:0]      out_param;
		logic [LVL_W-1:0] out_level;
		logic             last;
		logic             signal_raised;
		logic [TOT_W-1:0] pending_total;
		logic             cur_enabled;
		logic             delivery_requested;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_EMIT
	} fsm_t;

	// controller -> datapath
	typedef struct packed {
		logic take;   // request transfer this cycle
		logic rd;     // pop head of first eligible queue, read store
		logic emit;   // load delivered trap into result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic drain;     // current request is a deliver with traps to pop
		logic last;      // popped trap is the final one
		logic out_free;  // result register can take a new result
	} sts_t;

endpackage

FILE: design/four_level_priority_trap_queue_unit.sv
// Timing: a queue, set-enable or other request registers its result in the cycle after transfer.
// A deliver takes its traps one at a time through the registered read of the trap store
// followed by the result register load; a stalled result output holds a trap in the read stage.
// Throughput: one non-draining request per cycle while results are taken.
// Reset (arst_n low): queues empty, all levels enabled, request flag clear; the trap store
// is not cleared and only written slots are ever read.
// ----------------------------------------------------------------------------
// four_level_priority_trap_queue_unit: four-level priority trap queue
// Four FIFO trap queues with enable flags, drained in level order on request.
// ----------------------------------------------------------------------------
module four_level_priority_trap_queue_unit import fpltq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	cmd_t cmd;
	sts_t sts;

	// sequencing
	fpltq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// queue state and results
	fpltq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

FILE: design/fpltq_ctrl.sv
// ----------------------------------------------------------------------------
// fpltq_ctrl: sequencing controller
// Takes requests while idle, and walks a delivery as read / emit step pairs.
// ----------------------------------------------------------------------------
module fpltq_ctrl import fpltq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	fsm_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				req_stall = !sts.out_free;
				if (req_valid && sts.out_free) begin
					cmd.take = 1'b1;
					if (sts.drain) state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = sts.last ? S_IDLE : S_READ;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: design/fpltq_dp.sv
// ----------------------------------------------------------------------------
// fpltq_dp: queue datapath
// Per-level head, count and enable registers, the trap store, the delivery
// read stage and the result register.
// ----------------------------------------------------------------------------
module fpltq_dp import fpltq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  logic rsp_stall,
	output rsp_t rsp,
	output logic rsp_valid,
	input  cmd_t cmd,
	output sts_t sts
);

	// per-level control state
	logic [SLOT_W-1:0] head_q [LEVELS];
	logic [CNT_W-1:0]  cnt_q  [LEVELS];
	logic [LEVELS-1:0] en_q;
	logic              flag_q;

	// trap store: handler in the high half, parameter in the low half
	logic [63:0]       store_q [LEVELS*SLOTS];

	// delivery bookkeeping
	logic [TOT_W-1:0]  remain_q;
	logic [TOT_W-1:0]  total_q;
	logic              cur_en_q;
	logic [63:0]       ent_s1;
	logic [LVL_W-1:0]  lvl_s1;
	logic              last_s1;

	// result register
	rsp_t              rsp_q;
	logic              rsp_vld_q;

	// combinational decode
	logic [TOT_W-1:0]  tot_all, tot_en;
	logic [LEVELS-1:0] elig;
	logic [LVL_W-1:0]  sel;
	logic [LVL_W-1:0]  q_lvl;
	logic [LVL_W-1:0]  cur;
	logic [CNT_W-1:0]  pos_sum, pos;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic              q_ok, sig, wr_en, en_wr, load_imm;
	rsp_t              imm;

	assign cur   = req.cur_level;
	assign q_lvl = (req.level_req > MAX_LVL_B) ? MAX_LVL : req.level_req[LVL_W-1:0];

	// queue totals and eligibility for delivery
	always_comb begin
		tot_all = '0;
		tot_en  = '0;
		for (int l = 0; l < LEVELS; l++) begin
			elig[l] = en_q[l] && (cnt_q[l] != '0);
			tot_all = tot_all + TOT_W'(cnt_q[l]);
			if (en_q[l]) tot_en = tot_en + TOT_W'(cnt_q[l]);
		end
	end

	// lowest eligible level wins
	always_comb begin
		sel = '0;
		for (int l = LEVELS - 1; l >= 0; l--) begin
			if (elig[l]) sel = LVL_W'(l);
		end
	end

	// tail slot of the target queue
	assign pos_sum = CNT_W'(head_q[q_lvl]) + cnt_q[q_lvl];
	assign pos     = (pos_sum >= DEPTH_C) ? (pos_sum - DEPTH_C) : pos_sum;
	assign wr_addr = {q_lvl, pos[SLOT_W-1:0]};
	assign rd_addr = {sel, head_q[sel]};

	assign q_ok = (req.handler_token != '0) && (cnt_q[q_lvl] < DEPTH_C);

	// immediate result of a non-draining request
	always_comb begin
		imm             = '0;
		imm.last        = 1'b1;
		imm.cur_enabled = en_q[cur];
		imm.pending_total      = tot_all;
		imm.delivery_requested = flag_q;
		sig   = 1'b0;
		wr_en = 1'b0;
		en_wr = 1'b0;
		case (req.req_type)
			REQ_QUEUE: begin
				if (req.handler_token == '0) begin
					imm.status = ST_BADPARAM;
				end else if (!q_ok) begin
					imm.status = ST_LIMIT;
				end else begin
					imm.status        = ST_NORMAL;
					wr_en             = cmd.take;
					sig               = en_q[q_lvl];
					imm.pending_total = tot_all + TOT_W'(1);
				end
			end
			REQ_ENABLE: begin
				imm.status      = en_q[cur] ? ST_WASSET : ST_WASCLR;
				en_wr           = cmd.take;
				sig             = req.enable_bit && (cnt_q[cur] != '0);
				imm.cur_enabled = req.enable_bit;
			end
			REQ_DELIVER: begin
				imm.status             = ST_NORMAL;
				imm.delivery_requested = 1'b0;
			end
			default: begin
				imm.status = ST_BADPARAM;
			end
		endcase
		imm.signal_raised = sig;
		if (sig) imm.delivery_requested = 1'b1;
	end

	assign sts.drain    = (req.req_type == REQ_DELIVER) && (tot_en != '0);
	assign sts.last     = last_s1;
	assign sts.out_free = !rsp_vld_q || !rsp_stall;
	assign load_imm     = cmd.take && !sts.drain;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LEVELS; l++) begin
				head_q[l] <= '0;
				cnt_q[l]  <= '0;
			end
			en_q      <= '1;
			flag_q    <= 1'b0;
			remain_q  <= '0;
			last_s1   <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (wr_en) cnt_q[q_lvl] <= cnt_q[q_lvl] + CNT_W'(1);
			if (en_wr) en_q[cur] <= req.enable_bit;
			if (cmd.take) begin
				if (req.req_type == REQ_DELIVER) flag_q <= 1'b0;
				else if (sig) flag_q <= 1'b1;
				remain_q <= tot_en;
			end
			// pop the head of the selected queue
			if (cmd.rd) begin
				head_q[sel] <= (CNT_W'(head_q[sel]) == DEPTH_M1) ? '0 :
					head_q[sel] + SLOT_W'(1);
				cnt_q[sel]  <= cnt_q[sel] - CNT_W'(1);
				remain_q    <= remain_q - TOT_W'(1);
				last_s1     <= (remain_q == TOT_W'(1));
			end
			if (load_imm || cmd.emit) rsp_vld_q <= 1'b1;
			else if (!rsp_stall) rsp_vld_q <= 1'b0;
		end
	end

	// store, read stage and result payload
	always_ff @(posedge clk) begin
		if (wr_en) store_q[wr_addr] <= {req.handler_token, req.trap_param};
		if (cmd.rd) begin
			ent_s1 <= store_q[rd_addr];
			lvl_s1 <= sel;
		end
		if (cmd.take) begin
			total_q  <= tot_all - tot_en;
			cur_en_q <= en_q[cur];
		end
		if (load_imm) begin
			rsp_q <= imm;
		end else if (cmd.emit) begin
			rsp_q.status             <= ST_NORMAL;
			rsp_q.has_entry          <= 1'b1;
			rsp_q.out_handler        <= ent_s1[63:32];
			rsp_q.out_param          <= ent_s1[31:0];
			rsp_q.out_level          <= lvl_s1;
			rsp_q.last               <= last_s1;
			rsp_q.signal_raised      <= 1'b0;
			rsp_q.pending_total      <= total_q;
			rsp_q.cur_enabled        <= cur_en_q;
			rsp_q.delivery_requested <= 1'b0;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_vld_q;

	// no queue ever holds more than its depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q[0] <= DEPTH_C) && (cnt_q[1] <= DEPTH_C) &&
		(cnt_q[2] <= DEPTH_C) && (cnt_q[3] <= DEPTH_C))
		else $error("queue count above depth");

	// a pop always finds an eligible queue
	a_rd_elig: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> (elig != '0))
		else $error("pop with no eligible queue");

	// a pop is followed by its final flag only when the budget runs out
	a_rd_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |=> (last_s1 == ($past(remain_q) == TOT_W'(1))))
		else $error("last flag out of step with remaining count");

	// delivered traps never show a raised request flag or a status other than normal
	a_dlv_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_vld_q && rsp_q.has_entry) |-> (!rsp_q.delivery_requested &&
		(rsp_q.status == ST_NORMAL)))
		else $error("delivered trap with bad status or flag");

endmodule
